[design/bgi_pkg.sv]
// Shared constants, codes and control structs of the bilinear grid interpolator.
package bgi_pkg;

	localparam int MAX_ROWS  = 16;
	localparam int MAX_COLS  = 16;
	localparam int FRAC_BITS = 16;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int CNT_W     = 5;
	localparam int KNOT_W    = 32;
	localparam int WORD_W    = 32;
	localparam int DIV_STEPS = 31;
	localparam int OVF_SHIFT = DIV_STEPS - FRAC_BITS;
	localparam int S_DATA_W  = 136;
	localparam int S_USER_W  = 4;
	localparam int M_DATA_W  = 40;

	typedef enum logic [1:0] {
		MODE_ROW_KNOT = 2'd0,
		MODE_COL_KNOT = 2'd1,
		MODE_TABLE    = 2'd2,
		MODE_QUERY    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		LERP_TOP = 2'd0,
		LERP_BOT = 2'd1,
		LERP_MIX = 2'd2
	} lerp_sel_t;

	typedef struct packed {
		logic             load_in;
		logic             set_err;
		logic             lat_hi;
		logic             lat_lo;
		logic             div_start;
		logic             rd_en;
		logic [1:0]       corner;
		logic [ROW_W-1:0] row_addr;
		logic [COL_W-1:0] col_addr;
		logic             mul_en;
		logic             acc_en;
		lerp_sel_t        lerp_sel;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic gt_row;
		logic gt_col;
		logic div_done;
	} sts_t;

endpackage

[design/bgi_div.sv]
// Serial restoring divider that forms one saturated Q16 weight.
module bgi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] num,
	input  logic signed [32:0] den,
	output logic               busy,
	output logic signed [31:0] w
);
	import bgi_pkg::*;

	localparam logic [DIV_STEPS-1:0] W_LIM = DIV_STEPS'(1) << 30;

	logic                 busy_q;
	logic [4:0]           cnt_q;
	logic [32:0]          rem_q;
	logic [DIV_STEPS-1:0] sh_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic                 neg_q, zero_q, ovf_q;
	logic signed [31:0]   w_q;

	logic signed [32:0]   num_neg, den_neg;
	logic [31:0]          n_mag, d_mag;
	logic [32:0]          rem2;
	logic                 ge;
	logic [DIV_STEPS-1:0] mag;

	always_comb begin
		num_neg = -num;
		den_neg = -den;
		n_mag = num[32] ? num_neg[31:0] : num[31:0];
		d_mag = den[32] ? den_neg[31:0] : den[31:0];
		rem2 = {rem_q[31:0], sh_q[DIV_STEPS-1]};
		ge = rem2 >= {1'b0, d_mag};
		if (zero_q) begin
			mag = '0;
		end else if (ovf_q || quo_q > W_LIM) begin
			mag = W_LIM;
		end else begin
			mag = quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(DIV_STEPS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= 33'(n_mag >> OVF_SHIFT);
			sh_q   <= DIV_STEPS'({n_mag, {FRAC_BITS{1'b0}}});
			quo_q  <= '0;
			neg_q  <= num[32] ^ den[32];
			zero_q <= (d_mag == '0);
			ovf_q  <= 64'(n_mag) >= (64'(d_mag) << OVF_SHIFT);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				w_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			end else begin
				rem_q <= ge ? rem2 - {1'b0, d_mag} : rem2;
				sh_q  <= sh_q << 1;
				quo_q <= {quo_q[DIV_STEPS-2:0], ge};
			end
		end
	end

	assign busy = busy_q;
	assign w    = w_q;

endmodule

[design/bgi_dp.sv]
// Datapath: knot and table stores, weight dividers, blend multiplier and result registers.
module bgi_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bgi_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [bgi_pkg::S_USER_W-1:0]  s_tuser,
	input  bgi_pkg::cmd_t                 cmd,
	output bgi_pkg::sts_t                 sts,
	output logic [bgi_pkg::M_DATA_W-1:0]  m_tdata
);
	import bgi_pkg::*;

	logic [ROW_W-1:0]  in_row;
	logic [COL_W-1:0]  in_col;
	logic [KNOT_W-1:0] in_knot, in_qr, in_qc;
	logic [WORD_W-1:0] in_word;
	logic [1:0]        in_sel;
	mode_t             in_mode;

	logic [KNOT_W-1:0] row_knots_q [MAX_ROWS];
	logic [KNOT_W-1:0] col_knots_q [MAX_COLS];
	logic [WORD_W-1:0] tbl_mem [4*MAX_ROWS*MAX_COLS];

	logic [KNOT_W-1:0] qr_q, qc_q, rhi_q, rlo_q, chi_q, clo_q;
	logic [1:0]        sel_q;
	logic signed [WORD_W-1:0] corner_q [4];
	logic signed [WORD_W-1:0] r1_q, r2_q, res_q;
	logic                     err_q;
	logic signed [63:0]       prod_s1;
	logic [WORD_W-1:0]        out_val_q;
	logic                     out_err_q;

	logic [KNOT_W-1:0]        rk, ck;
	logic signed [32:0]       t_num, t_den, u_num, u_den;
	logic signed [31:0]       t_w, u_w, w_op;
	logic                     t_busy, u_busy;
	logic signed [WORD_W-1:0] a_op, b_op;
	logic signed [32:0]       diff;
	logic signed [63:0]       sum;
	logic signed [WORD_W-1:0] sat;

	assign in_mode = mode_t'(s_tuser[1:0]);
	assign in_sel  = s_tuser[3:2];
	assign in_row  = s_tdata[3:0];
	assign in_col  = s_tdata[7:4];
	assign in_knot = s_tdata[39:8];
	assign in_word = s_tdata[71:40];
	assign in_qr   = s_tdata[103:72];
	assign in_qc   = s_tdata[135:104];

	assign rk = row_knots_q[cmd.row_addr];
	assign ck = col_knots_q[cmd.col_addr];

	assign sts.gt_row   = qr_q > rk;
	assign sts.gt_col   = qc_q > ck;
	assign sts.div_done = !t_busy && !u_busy;

	assign t_num = $signed({1'b0, qr_q}) - $signed({1'b0, rlo_q});
	assign t_den = $signed({1'b0, rhi_q}) - $signed({1'b0, rlo_q});
	assign u_num = $signed({1'b0, qc_q}) - $signed({1'b0, clo_q});
	assign u_den = $signed({1'b0, chi_q}) - $signed({1'b0, clo_q});

	bgi_div u_div_t (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(t_num), .den(t_den), .busy(t_busy), .w(t_w)
	);

	bgi_div u_div_u (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(u_num), .den(u_den), .busy(u_busy), .w(u_w)
	);

	always_comb begin
		case (cmd.lerp_sel)
			LERP_TOP: begin
				a_op = corner_q[0];
				b_op = corner_q[1];
				w_op = u_w;
			end
			LERP_BOT: begin
				a_op = corner_q[2];
				b_op = corner_q[3];
				w_op = u_w;
			end
			default: begin
				a_op = r1_q;
				b_op = r2_q;
				w_op = t_w;
			end
		endcase
		diff = 33'(b_op) - 33'(a_op);
		// Arithmetic shift rounds toward minus infinity, which is the floor we need.
		sum = 64'(a_op) + (prod_s1 >>> FRAC_BITS);
		if (sum > 64'sd2147483647) begin
			sat = 32'sh7fff_ffff;
		end else if (sum < -64'sd2147483648) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = sum[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			qr_q  <= in_qr;
			qc_q  <= in_qc;
			sel_q <= in_sel;
			unique case (in_mode)
				MODE_ROW_KNOT: row_knots_q[in_row] <= in_knot;
				MODE_COL_KNOT: col_knots_q[in_col] <= in_knot;
				MODE_TABLE:    tbl_mem[{in_sel, in_row, in_col}] <= in_word;
				default: ;
			endcase
		end
		if (cmd.rd_en) begin
			corner_q[cmd.corner] <= tbl_mem[{sel_q, cmd.row_addr, cmd.col_addr}];
		end
		if (cmd.lat_hi) begin
			rhi_q <= rk;
			chi_q <= ck;
		end
		if (cmd.lat_lo) begin
			rlo_q <= rk;
			clo_q <= ck;
		end
		if (cmd.mul_en) begin
			prod_s1 <= 64'(diff * w_op);
		end
		if (cmd.set_err) begin
			res_q <= '0;
			err_q <= 1'b1;
		end else if (cmd.acc_en) begin
			case (cmd.lerp_sel)
				LERP_TOP: r1_q <= sat;
				LERP_BOT: r2_q <= sat;
				default: begin
					res_q <= sat;
					err_q <= 1'b0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_val_q <= res_q;
			out_err_q <= err_q;
		end
	end

	assign m_tdata = {7'b0, out_err_q, out_val_q};

endmodule

[design/bgi_ctrl.sv]
// Controller: configuration registers, query sequencer and output handshake.
module bgi_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [bgi_pkg::CNT_W-1:0]  cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [1:0]                 s_mode,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	input  bgi_pkg::sts_t              sts,
	output bgi_pkg::cmd_t              cmd
);
	import bgi_pkg::*;

	localparam logic CFG_ROW_COUNT = 1'b0;
	localparam logic CFG_COL_COUNT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_SEARCH, ST_LOAD_HI, ST_LOAD_LO,
		ST_DIV_GO, ST_DIV_WAIT, ST_MUL, ST_ACC, ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] row_count_q, col_count_q;
	logic [ROW_W-1:0] row_i_q;
	logic [COL_W-1:0] col_j_q;
	logic [2:0]       fetch_q;
	lerp_sel_t        lsel_q;
	logic             m_tvalid_q;

	logic [ROW_W-1:0] row_last;
	logic [COL_W-1:0] col_last;
	logic             accept, row_step, col_step, out_free;

	always_comb begin
		if (row_count_q < CNT_W'(2)) begin
			row_last = ROW_W'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			row_last = ROW_W'(MAX_ROWS - 1);
		end else begin
			row_last = ROW_W'(row_count_q - CNT_W'(1));
		end
		if (col_count_q < CNT_W'(2)) begin
			col_last = COL_W'(1);
		end else if (int'(col_count_q) > MAX_COLS) begin
			col_last = COL_W'(MAX_COLS - 1);
		end else begin
			col_last = COL_W'(col_count_q - CNT_W'(1));
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign row_step = (row_i_q < row_last) && sts.gt_row;
	assign col_step = (col_j_q < col_last) && sts.gt_col;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd = '0;
		cmd.load_in  = accept;
		cmd.row_addr = row_i_q;
		cmd.col_addr = col_j_q;
		cmd.lerp_sel = lsel_q;
		cmd.corner   = fetch_q[1:0];
		unique case (state_q)
			ST_CHECK: begin
				cmd.row_addr = row_last;
				cmd.col_addr = col_last;
				cmd.set_err  = sts.gt_row || sts.gt_col;
			end
			ST_LOAD_HI: cmd.lat_hi = 1'b1;
			ST_LOAD_LO: begin
				cmd.row_addr = row_i_q - ROW_W'(1);
				cmd.col_addr = col_j_q - COL_W'(1);
				cmd.lat_lo   = 1'b1;
			end
			ST_DIV_GO: cmd.div_start = 1'b1;
			ST_DIV_WAIT: begin
				// Corners in order: upper-left, upper-right, lower-left, lower-right.
				cmd.rd_en    = !fetch_q[2];
				cmd.row_addr = fetch_q[1] ? row_i_q : row_i_q - ROW_W'(1);
				cmd.col_addr = fetch_q[0] ? col_j_q : col_j_q - COL_W'(1);
			end
			ST_MUL:    cmd.mul_en = 1'b1;
			ST_ACC:    cmd.acc_en = 1'b1;
			ST_FINISH: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_count_q <= CNT_W'(16);
			col_count_q <= CNT_W'(16);
			row_i_q     <= '0;
			col_j_q     <= '0;
			fetch_q     <= '0;
			lsel_q      <= LERP_TOP;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROW_COUNT: row_count_q <= cfg_data;
					CFG_COL_COUNT: col_count_q <= cfg_data;
					default: ;
				endcase
			end
			// A new result loaded in the finish step takes precedence over the clear.
			if (m_tvalid_q && m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && mode_t'(s_mode) == MODE_QUERY) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					row_i_q <= ROW_W'(1);
					col_j_q <= COL_W'(1);
					state_q <= (sts.gt_row || sts.gt_col) ? ST_FINISH : ST_SEARCH;
				end
				ST_SEARCH: begin
					if (row_step) begin
						row_i_q <= row_i_q + ROW_W'(1);
					end
					if (col_step) begin
						col_j_q <= col_j_q + COL_W'(1);
					end
					if (!row_step && !col_step) begin
						state_q <= ST_LOAD_HI;
					end
				end
				ST_LOAD_HI: state_q <= ST_LOAD_LO;
				ST_LOAD_LO: state_q <= ST_DIV_GO;
				ST_DIV_GO: begin
					fetch_q <= '0;
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (!fetch_q[2]) begin
						fetch_q <= fetch_q + 3'd1;
					end else if (sts.div_done) begin
						lsel_q  <= LERP_TOP;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					unique case (lsel_q)
						LERP_TOP: begin
							lsel_q  <= LERP_BOT;
							state_q <= ST_MUL;
						end
						LERP_BOT: begin
							lsel_q  <= LERP_MIX;
							state_q <= ST_MUL;
						end
						default: state_q <= ST_FINISH;
					endcase
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_t'(s_mode) == MODE_QUERY) |=> (state_q == ST_CHECK))
		else $error("query beat did not start the range check");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_GO) |=> !sts.div_done)
		else $error("dividers did not start");
	a_seg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (row_i_q != '0 && col_j_q != '0))
		else $error("segment index fell to zero");
	a_mul_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_ACC && $stable(lsel_q)))
		else $error("blend step out of order");
`endif

endmodule

[design/bilinear_grid_interpolator.sv]
// Top level of the bilinear interpolator over a nonuniform knot grid.
//
//   Channel  Direction  Handshake           Contents
//   s_*      in         s_tvalid/s_tready   knot, table word or query beat
//   m_*      out        m_tvalid/m_tready   interpolated value and range flag
//   cfg_*    in         cfg_we              row_count (index 0), col_count (index 1)
//
// A knot or table write beat is stored at the edge that accepts it. A query runs through
// a range check, a linear knot search that steps both axes together and closes once
// neither axis steps further, states that latch the segment knots and start the
// dividers, a wait while two 31-step serial dividers run side by side and the four
// corner words are read, three multiply and add steps, and the load of the output
// register. A query above the last knot goes from the range check straight to that load.
// Reset is asynchronous and clears only control state; the knot and table stores hold
// nothing useful until written. The output register lets the next beat be taken while
// a result waits on a stalled m_tready.
module bilinear_grid_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bgi_pkg::CNT_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// row_index[3:0], col_index[7:4], knot_value[39:8], table_word[71:40],
	// query_row[103:72], query_col[135:104]
	input  logic [bgi_pkg::S_DATA_W-1:0]  s_tdata,
	// mode[1:0], table_sel[3:2]
	input  logic [bgi_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// interp_value[31:0], out_of_range[32], zero fill above
	output logic [bgi_pkg::M_DATA_W-1:0]  m_tdata
);
	import bgi_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences each query; the datapath owns all stores and arithmetic.
	bgi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_mode(s_tuser[1:0]),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.sts(sts), .cmd(cmd)
	);

	bgi_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.cmd(cmd), .sts(sts), .m_tdata(m_tdata)
	);

endmodule
